/* sv/maze_visit_count_navigator_defines.svh */
// Assertion macros for the maze visit-count navigator.
// Used by the top level only; needs clk and rst_n in scope.
`ifndef MAZE_VISIT_COUNT_NAVIGATOR_DEFINES_SVH
`define MAZE_VISIT_COUNT_NAVIGATOR_DEFINES_SVH

// same-cycle implication
`define MVCN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mvcn: same-cycle check failed");

// next-cycle implication
`define MVCN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mvcn: next-cycle check failed");

`endif

/* sv/mvcn_pkg.sv */
// Shared constants and codes for the maze visit-count navigator.
// No dependencies.
package mvcn_pkg;

  localparam int GRID_SIZE  = 16;
  localparam int COUNT_BITS = 8;

  localparam int COORD_W = $clog2(GRID_SIZE);
  localparam int CELLS   = GRID_SIZE * GRID_SIZE;
  localparam int CELL_W  = $clog2(CELLS);

  localparam int GOAL_W  = 4;
  localparam int OUT_C_W = 4;
  localparam int CMP_W   = ((COORD_W > GOAL_W) ? COORD_W : GOAL_W) + 1;

  localparam logic [COORD_W-1:0]    COORD_MAX = COORD_W'(GRID_SIZE - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef logic [1:0]            heading_t;
  typedef logic [2:0]            action_t;
  typedef logic [COORD_W-1:0]    coord_t;
  typedef logic [CELL_W-1:0]     cell_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  localparam heading_t HDG_N = 2'd0;
  localparam heading_t HDG_E = 2'd1;
  localparam heading_t HDG_S = 2'd2;
  localparam heading_t HDG_W = 2'd3;

  localparam action_t ACT_FWD   = 3'd0;
  localparam action_t ACT_RIGHT = 3'd1;
  localparam action_t ACT_LEFT  = 3'd2;
  localparam action_t ACT_UTURN = 3'd3;
  localparam action_t ACT_GOAL  = 3'd4;

  localparam int          PADDR_W  = 3;
  localparam int          PDATA_W  = 32;
  localparam logic        REG_GOAL_X = 1'b0;
  localparam logic        REG_GOAL_Y = 1'b1;
  localparam logic [GOAL_W-1:0] GOAL_RST = 4'd7;

endpackage

/* sv/maze_visit_count_navigator.sv */
// Visit-count maze explorer: one move decision per sensed wall triple.
// Result registered through S_WR: at goal directly; walls decide alone via S_DEC;
// two neighbour counts compared via S_RD_B then S_DEC, read one after another
// through the single read port. One item at a time; S_WR holds while stalled.
// Reset (rst_n low, synchronous): heading north, position (0,0), goal (7,7),
// all 256 per-entry valid bits cleared so every count reads zero at once.
module maze_visit_count_navigator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_wall_left,
  input  logic                             in_wall_front,
  input  logic                             in_wall_right,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       out_action,
  output logic [3:0]                       out_next_x,
  output logic [3:0]                       out_next_y,
  output logic [1:0]                       out_next_heading,
  output logic                             out_at_goal,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [mvcn_pkg::PADDR_W-1:0]     cfg_paddr,
  input  logic [mvcn_pkg::PDATA_W-1:0]     cfg_pwdata,
  output logic [mvcn_pkg::PDATA_W-1:0]     cfg_prdata,
  output logic                             cfg_pready
);
  import mvcn_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD_B = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;

  function automatic logic nb_off(input heading_t d, input coord_t x, input coord_t y);
    logic off;
    case (d)
      HDG_N:   off = (y == COORD_MAX);
      HDG_E:   off = (x == COORD_MAX);
      HDG_S:   off = (y == '0);
      default: off = (x == '0);
    endcase
    return off;
  endfunction

  function automatic coord_t nb_x(input heading_t d, input coord_t x);
    coord_t r;
    case (d)
      HDG_E:   r = x + 1'b1;
      HDG_W:   r = x - 1'b1;
      default: r = x;
    endcase
    return r;
  endfunction

  function automatic coord_t nb_y(input heading_t d, input coord_t y);
    coord_t r;
    case (d)
      HDG_N:   r = y + 1'b1;
      HDG_S:   r = y - 1'b1;
      default: r = y;
    endcase
    return r;
  endfunction

  function automatic cell_t cell_idx(input coord_t x, input coord_t y);
    return CELL_W'(CELL_W'(x) * CELL_W'(GRID_SIZE)) + CELL_W'(y);
  endfunction

  logic [2:0]          state_r, state_nxt;
  heading_t            heading_r, heading_nxt;
  coord_t              pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic [GOAL_W-1:0]   goal_x_r, goal_y_r;
  logic [2:0]          walls_r;
  action_t             act_r, act_nxt;
  count_t              cnt_a_r;

  count_t              mem [CELLS];
  logic [CELLS-1:0]    vld_r;
  count_t              rd_data_r;
  logic                rd_vld_r, rd_off_r;
  logic                mem_re, mem_we, rd_off_nxt;
  cell_t               mem_raddr;
  count_t              mem_wdata, rd_cnt;

  logic                in_acc, cfg_wr, out_free, fire_wr, cur_goal, need_cmp_in;
  logic                wl, wf, wr, a_le_b;
  heading_t            dir_a, dir_b;
  logic [CMP_W-1:0]    gx_lo, gy_lo, px_c, py_c;

  // goal test on the current position
  assign gx_lo    = CMP_W'(goal_x_r);
  assign gy_lo    = CMP_W'(goal_y_r);
  assign px_c     = CMP_W'(pos_x_r);
  assign py_c     = CMP_W'(pos_y_r);
  assign cur_goal = (px_c >= gx_lo) && (px_c <= gx_lo + 1'b1) &&
                    (py_c >= gy_lo) && (py_c <= gy_lo + 1'b1);

  assign in_ready    = (state_r == S_IDLE);
  assign in_acc      = in_valid && in_ready;
  assign need_cmp_in = (in_wall_left ^ in_wall_front ^ in_wall_right) &&
                       !(in_wall_left && in_wall_front && in_wall_right);
  assign out_free    = !out_valid || out_ready;
  assign fire_wr     = (state_r == S_WR) && out_free;
  assign mem_we      = fire_wr && (act_r != ACT_GOAL);
  assign mem_wdata   = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + 1'b1;

  assign wl = walls_r[2];
  assign wf = walls_r[1];
  assign wr = walls_r[0];

  // first compared neighbour: forward if left is closed, else left
  assign dir_a = in_wall_left ? heading_r : heading_t'(heading_r + 2'd3);
  // second: right if left closed, forward if right closed, else right
  assign dir_b = (!wl && wr) ? heading_r : heading_t'(heading_r + 2'd1);

  assign rd_cnt = rd_off_r ? COUNT_MAX : (rd_vld_r ? rd_data_r : '0);
  assign a_le_b = (cnt_a_r <= rd_cnt);

  always_comb begin
    mem_re     = 1'b0;
    mem_raddr  = '0;
    rd_off_nxt = 1'b0;
    if (in_acc && !cur_goal && need_cmp_in) begin
      mem_re     = 1'b1;
      mem_raddr  = cell_idx(nb_x(dir_a, pos_x_r), nb_y(dir_a, pos_y_r));
      rd_off_nxt = nb_off(dir_a, pos_x_r, pos_y_r);
    end else if (state_r == S_RD_B) begin
      mem_re     = 1'b1;
      mem_raddr  = cell_idx(nb_x(dir_b, pos_x_r), nb_y(dir_b, pos_y_r));
      rd_off_nxt = nb_off(dir_b, pos_x_r, pos_y_r);
    end else if (state_r == S_DEC) begin
      mem_re     = 1'b1;
      mem_raddr  = cell_idx(pos_x_nxt, pos_y_nxt);
    end
  end

  always_comb begin
    if (wl && wf && wr) begin
      act_nxt = ACT_UTURN;
    end else if (!wl && !wf && !wr) begin
      act_nxt = ACT_RIGHT;
    end else if (wl && wr) begin
      act_nxt = ACT_FWD;
    end else if (wl && wf) begin
      act_nxt = ACT_RIGHT;
    end else if (wf && wr) begin
      act_nxt = ACT_LEFT;
    end else if (wl) begin
      act_nxt = (rd_cnt <= cnt_a_r) ? ACT_RIGHT : ACT_FWD;
    end else if (wr) begin
      act_nxt = a_le_b ? ACT_LEFT : ACT_FWD;
    end else begin
      act_nxt = a_le_b ? ACT_LEFT : ACT_RIGHT;
    end

    case (act_nxt)
      ACT_RIGHT: heading_nxt = heading_r + 2'd1;
      ACT_LEFT:  heading_nxt = heading_r + 2'd3;
      ACT_UTURN: heading_nxt = heading_r + 2'd2;
      default:   heading_nxt = heading_r;
    endcase

    if (nb_off(heading_nxt, pos_x_r, pos_y_r)) begin
      pos_x_nxt = pos_x_r;
      pos_y_nxt = pos_y_r;
    end else begin
      pos_x_nxt = nb_x(heading_nxt, pos_x_r);
      pos_y_nxt = nb_y(heading_nxt, pos_y_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (cur_goal) begin
            state_nxt = S_WR;
          end else if (need_cmp_in) begin
            state_nxt = S_RD_B;
          end else begin
            state_nxt = S_DEC;
          end
        end
      end
      S_RD_B:  state_nxt = S_DEC;
      S_DEC:   state_nxt = S_WR;
      S_WR: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // count memory, one read and one write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cell_idx(pos_x_r, pos_y_r)] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      rd_off_r <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_r[cell_idx(pos_x_r, pos_y_r)] <= 1'b1;
      end
      if (mem_re) begin
        rd_vld_r <= vld_r[mem_raddr];
        rd_off_r <= rd_off_nxt;
      end
    end
  end

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_GOAL_Y) ? PDATA_W'(goal_y_r) :
                                                     PDATA_W'(goal_x_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      heading_r <= HDG_N;
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      goal_x_r  <= GOAL_RST;
      goal_y_r  <= GOAL_RST;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        if (cfg_paddr[2] == REG_GOAL_X) begin
          goal_x_r <= cfg_pwdata[GOAL_W-1:0];
        end else begin
          goal_y_r <= cfg_pwdata[GOAL_W-1:0];
        end
      end
      if (state_r == S_DEC) begin
        heading_r <= heading_nxt;
        pos_x_r   <= pos_x_nxt;
        pos_y_r   <= pos_y_nxt;
      end
      if (fire_wr) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      walls_r <= {in_wall_left, in_wall_front, in_wall_right};
      act_r   <= ACT_GOAL;
    end
    if (state_r == S_RD_B) begin
      cnt_a_r <= rd_cnt;
    end
    if (state_r == S_DEC) begin
      act_r <= act_nxt;
    end
    if (fire_wr) begin
      out_action       <= act_r;
      out_next_x       <= OUT_C_W'(pos_x_r);
      out_next_y       <= OUT_C_W'(pos_y_r);
      out_next_heading <= heading_r;
      out_at_goal      <= cur_goal;
    end
  end

`include "maze_visit_count_navigator_defines.svh"

  `MVCN_ASSERT_NOW(a_goal_result, out_valid && (out_action == ACT_GOAL), out_at_goal)
  `MVCN_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_r != S_IDLE)
  `MVCN_ASSERT_NOW(a_count_write_nonzero, mem_we, (mem_wdata != '0) && !mem_re)

endmodule
